// File: rtl/sbma_pkg.sv
// ----------------------------------------------------------------------------
// sbma_pkg
// Shared types, widths and codes of the sized byte memory access block.
// ----------------------------------------------------------------------------
package sbma_pkg;

  // Field widths.
  localparam int ADDR_W    = 64;
  localparam int DATA_W    = 64;
  localparam int SIZE_W    = 4;
  localparam int MEMB_W    = 17;
  localparam int CFG_IDX_W = 1;

  // Default memory depth in bytes.
  localparam int DEF_MEM_BYTES = 65536;

  // Register reset values.
  localparam logic [ADDR_W-1:0] RST_BASE_ADDRESS = 64'h0000_0000_8000_0000;
  localparam int                RST_MEM_BYTES    = 65536;

  // Mask for one byte lane.
  localparam logic [7:0] BYTE_MASK = 8'hFF;

  // Request kinds.
  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_STORE = 2'd1,
    OP_FETCH = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  // Fetch width in bytes.
  localparam logic [SIZE_W-1:0] FETCH_BYTES = 4'd4;

  // Result status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_SIZE  = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDRESS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MEMORY_BYTES = 1'b1;

endpackage

// File: rtl/sbma_req_if.sv
// ----------------------------------------------------------------------------
// sbma_req_if
// Request channel: operation, address, size and store data.
// ----------------------------------------------------------------------------
interface sbma_req_if
  import sbma_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [1:0]          operation;
  logic [ADDR_W-1:0]   address;
  logic [SIZE_W-1:0]   size_bytes;
  logic [DATA_W-1:0]   write_data;

  modport source (output valid, operation, address, size_bytes, write_data, input ready);
  modport sink   (input valid, operation, address, size_bytes, write_data, output ready);
endinterface

// File: rtl/sbma_rsp_if.sv
// ----------------------------------------------------------------------------
// sbma_rsp_if
// Result channel: read data and status.
// ----------------------------------------------------------------------------
interface sbma_rsp_if
  import sbma_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] read_data;
  logic [1:0]        status;

  modport source (output valid, read_data, status, input ready);
  modport sink   (input valid, read_data, status, output ready);
endinterface

// File: rtl/sbma_cfg_if.sv
// ----------------------------------------------------------------------------
// sbma_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface sbma_cfg_if
  import sbma_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] wr_index;
  logic [DATA_W-1:0]    wr_data;

  modport source (output valid, wr_index, wr_data, input ready);
  modport sink   (input valid, wr_index, wr_data, output ready);
endinterface

// File: rtl/sized_byte_memory_access.sv
// ----------------------------------------------------------------------------
// sized_byte_memory_access
// Byte-addressed little-endian memory with sized loads, stores and fetches.
// ----------------------------------------------------------------------------
// Each request passes through these steps, the first in the cycle in which it
// is accepted: the subtraction of the base address, the range and size
// check, the access to the eight byte-lane banks and the line-up of the
// registered bank data; the result then goes into the output register. One
// request is in flight at a time, so a new request is taken only after the
// last one has passed the final step; a finished result waits
// in the output register while the next request is already taken. A result
// that finds the output register still full holds the last step, and the
// input stays stalled until the receiver takes the older result. The banks
// hold MEM_BYTES bytes, eight lanes of ceil(MEM_BYTES/8) rows, and any
// alignment is served in one access, including spans across a row boundary.
// Memory contents are undefined until written and get no clearing pass.
// Configuration writes are always accepted and must be made while idle.
module sized_byte_memory_access
  import sbma_pkg::*;
#(
  parameter int MEM_BYTES = DEF_MEM_BYTES
) (
  input  logic       clk,
  input  logic       rst_n,
  sbma_req_if.sink   in_ch,
  sbma_rsp_if.source out_ch,
  sbma_cfg_if.sink   cfg_ch
);

  localparam int ROWS     = (MEM_BYTES + 7) / 8;
  localparam int ROW_W    = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int LIM_W    = ($clog2(MEM_BYTES + 1) > MEMB_W) ? $clog2(MEM_BYTES + 1) : MEMB_W;
  localparam int LIM_RSTI = (RST_MEM_BYTES > MEM_BYTES) ? MEM_BYTES : RST_MEM_BYTES;
  localparam logic [LIM_W-1:0] LIM_MAX = LIM_W'(MEM_BYTES);
  localparam logic [LIM_W-1:0] LIM_RST = LIM_W'(LIM_RSTI);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_CHECK = 4'b0010,
    S_MEM   = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t              state_r, state_nxt;
  logic [ADDR_W-1:0]   base_r;
  logic [LIM_W-1:0]    limit_r;
  logic [1:0]          op_r;
  logic [SIZE_W-1:0]   size_r;
  logic [DATA_W-1:0]   wdata_r;
  logic [ADDR_W:0]     off_r;
  logic [1:0]          chk_st_r, chk_st_nxt;
  logic                out_valid_r;
  logic [DATA_W-1:0]   read_data_r;
  logic [1:0]          status_r;

  logic                in_fire;
  logic                out_load;
  logic [SIZE_W-1:0]   acc_len;
  logic [ADDR_W:0]     end_sum;
  logic                range_ok;
  logic                size_ok;
  logic [ROW_W-1:0]    base_row;
  logic [7:0]          mem_we;
  logic [ROW_W-1:0]    mem_row [8];
  logic [7:0]          mem_wd  [8];
  logic [7:0]          bank_q  [8];
  logic [DATA_W-1:0]   rd_data;
  logic [MEMB_W-1:0]   cfg_memb;

  assign in_fire      = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;

  // Configuration registers; the size limit is stored already clamped.
  assign cfg_memb = cfg_ch.wr_data[MEMB_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r  <= RST_BASE_ADDRESS;
      limit_r <= LIM_RST;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.wr_index)
        CFG_BASE_ADDRESS: base_r <= cfg_ch.wr_data;
        CFG_MEMORY_BYTES: begin
          limit_r <= (LIM_W'(cfg_memb) > LIM_MAX) ? LIM_MAX : LIM_W'(cfg_memb);
        end
        default: ;
      endcase
    end
  end

  // Request capture and base subtraction; bit 64 of the offset is the borrow.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r    <= in_ch.operation;
      size_r  <= in_ch.size_bytes;
      wdata_r <= in_ch.write_data;
      off_r   <= {1'b0, in_ch.address} - {1'b0, base_r};
    end
  end

  // Range check without wrap, then the size check.
  assign acc_len  = (op_r == OP_FETCH) ? FETCH_BYTES : size_r;
  assign end_sum  = {1'b0, off_r[ADDR_W-1:0]} + (ADDR_W + 1)'(acc_len);
  assign range_ok = !off_r[ADDR_W] && (end_sum <= (ADDR_W + 1)'(limit_r));
  assign size_ok  = (size_r == 4'd1) || (size_r == 4'd2) || (size_r == 4'd4)
                 || (size_r == 4'd8);

  always_comb begin
    if (op_r == OP_NONE) begin
      chk_st_nxt = ST_SIZE;
    end else if (!range_ok) begin
      chk_st_nxt = ST_RANGE;
    end else if (op_r != OP_FETCH && !size_ok) begin
      chk_st_nxt = ST_SIZE;
    end else begin
      chk_st_nxt = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_CHECK) begin
      chk_st_r <= chk_st_nxt;
    end
  end

  // Lane addressing: lanes below the start lane take the next row.
  assign base_row = off_r[ROW_W+2:3];

  always_comb begin
    logic [2:0] k;
    for (int b = 0; b < 8; b++) begin
      k          = 3'(b) - off_r[2:0];
      mem_row[b] = (3'(b) >= off_r[2:0]) ? base_row : base_row + ROW_W'(1);
      mem_we[b]  = (state_r == S_MEM) && (chk_st_r == ST_OK) && (op_r == OP_STORE)
                && ({1'b0, k} < size_r);
      mem_wd[b]  = 8'(wdata_r >> {k, 3'b000}) & BYTE_MASK;
    end
  end

  // Eight byte-lane banks with registered read data.
  for (genvar b = 0; b < 8; b++) begin : g_bank
    logic [7:0] bank_mem [ROWS];

    always_ff @(posedge clk) begin
      if (mem_we[b]) begin
        bank_mem[mem_row[b]] <= mem_wd[b];
      end
      if (state_r == S_MEM) begin
        bank_q[b] <= bank_mem[mem_row[b]];
      end
    end
  end

  // Reassemble the bytes in access order and zero the unused ones.
  always_comb begin
    logic [2:0] lane;
    rd_data = '0;
    for (int k = 0; k < 8; k++) begin
      lane = off_r[2:0] + 3'(k);
      if ((chk_st_r == ST_OK) && (op_r != OP_STORE) && (SIZE_W'(k) < acc_len)) begin
        rd_data[8*k +: 8] = bank_q[lane];
      end
    end
  end

  // Sequencer.
  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_ch.ready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_fire) state_nxt = S_CHECK;
      S_CHECK: state_nxt = S_MEM;
      S_MEM:   state_nxt = S_DONE;
      S_DONE:  if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      read_data_r <= rd_data;
      status_r    <= chk_st_r;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.read_data = read_data_r;
  assign out_ch.status    = status_r;

`ifndef ASSERT_OFF
  // An accepted request always moves on to the check.
  a_accept_to_check: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == S_CHECK))
    else $error("accepted request did not enter the check");

  // Bank writes happen only for a store that passed every check.
  a_write_only_ok_store: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we != 8'd0) |-> ((chk_st_r == ST_OK) && (op_r == OP_STORE)))
    else $error("bank write for a failed or non-store request");

  // A failed request reports zero read data.
  a_fail_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (status_r != ST_OK)) |-> (read_data_r == '0))
    else $error("failed request returned nonzero data");

  // A finished request lands in the output register.
  a_done_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (out_valid_r && (state_r == S_IDLE)))
    else $error("finished request not presented");
`endif

endmodule

// File: sim/sized_byte_memory_access_tb.sv
// ----------------------------------------------------------------------------
// sized_byte_memory_access_tb
// Self-checking bench for the sized byte memory: a directed table of edge
// requests, then random loads, stores and fetches under several base and
// size settings, each result compared with an in-bench memory image.
// ----------------------------------------------------------------------------
module sized_byte_memory_access_tb;
  import sbma_pkg::*;

  localparam int MEM_DEPTH    = DEF_MEM_BYTES;
  localparam int LIMIT_CYCLES = 400000;
  localparam int LONG_HOLD    = 300;
  localparam int DRAIN_SLACK  = 8;
  localparam int NUM_PHASES   = 8;

  typedef struct packed {
    op_t               op;
    logic [ADDR_W-1:0] addr;
    logic [SIZE_W-1:0] size;
    logic [DATA_W-1:0] wdata;
  } mem_req_t;

  typedef struct packed {
    logic [DATA_W-1:0] rdata;
    logic [1:0]        status;
  } mem_rsp_t;

  typedef struct {
    mem_req_t req;
    bit       fixed;
    mem_rsp_t rsp;
  } dir_row_t;

  logic clk;
  logic rst_n;

  sbma_req_if req_bus ();
  sbma_rsp_if rsp_bus ();
  sbma_cfg_if cfg_bus ();

  sized_byte_memory_access #(
    .MEM_BYTES(MEM_DEPTH)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (req_bus.sink),
    .out_ch(rsp_bus.source),
    .cfg_ch(cfg_bus.sink)
  );

  // Memory image and register copies kept by the bench.
  logic [7:0]        mem_image    [MEM_DEPTH];
  bit                byte_written [MEM_DEPTH];
  logic [ADDR_W-1:0] cfg_base;
  logic [MEMB_W-1:0] cfg_mem_bytes;
  logic [MEMB_W-1:0] cur_limit;

  mem_rsp_t awaited_rsp [$];
  dir_row_t dir_rows [$];

  int  cycle_count;
  int  mismatches;
  int  n_load, n_store, n_fetch, n_noop;
  int  n_ok, n_range, n_size;
  int  n_settings;
  int  n_holds;
  bit  long_hold_req;

  // Clock with period 8.
  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Free-running cycle counter that ends a hung run.
  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timeout after %0d cycles with %0d results pending", cycle_count,
             awaited_rsp.size());
    $display("*** FAILED ***");
    $finish;
  end

  // Expected response of one request; stores update the image.
  task automatic compute_memory_response(input mem_req_t r, output mem_rsp_t p);
    logic [ADDR_W-1:0] offset;
    logic [SIZE_W-1:0] nbytes;
    logic [15:0]       idx;
    bit                fits;
    p       = '0;
    nbytes  = (r.op == OP_FETCH) ? FETCH_BYTES : r.size;
    offset  = r.addr - cfg_base;
    // The 65-bit sum keeps offset plus width from wrapping.
    fits    = (r.addr >= cfg_base) &&
              (({1'b0, offset} + 65'(nbytes)) <= 65'(cur_limit));
    if (r.op == OP_NONE) begin
      p.status = ST_SIZE;
    end else if (!fits) begin
      p.status = ST_RANGE;
    end else if (r.op != OP_FETCH && r.size != 4'd1 && r.size != 4'd2 &&
                 r.size != 4'd4 && r.size != 4'd8) begin
      p.status = ST_SIZE;
    end else begin
      p.status = ST_OK;
      for (int i = 0; i < nbytes; i++) begin
        idx = offset[15:0] + 16'(i);
        if (r.op == OP_STORE) begin
          mem_image[idx]    = r.wdata[8*i +: 8] & BYTE_MASK;
          byte_written[idx] = 1'b1;
        end else begin
          p.rdata[8*i +: 8] = mem_image[idx];
        end
      end
    end
  endtask

  function automatic dir_row_t make_row(op_t op, logic [ADDR_W-1:0] addr,
                                        logic [SIZE_W-1:0] size,
                                        logic [DATA_W-1:0] wdata, bit fixed,
                                        logic [DATA_W-1:0] rdata,
                                        logic [1:0] status);
    dir_row_t row;
    row.req.op    = op;
    row.req.addr  = addr;
    row.req.size  = size;
    row.req.wdata = wdata;
    row.fixed     = fixed;
    row.rsp.rdata = rdata;
    row.rsp.status = status;
    return row;
  endfunction

  // Random request, mostly aimed inside the window near both ends.
  task automatic make_random_request(output mem_req_t r);
    int unsigned       lim;
    int unsigned       win;
    int unsigned       pick;
    logic [ADDR_W-1:0] off;
    logic [ADDR_W-1:0] offset;
    logic [SIZE_W-1:0] nbytes;
    bit                unread;
    lim  = cur_limit;
    win  = (lim < 64) ? lim : 64;
    pick = $urandom_range(0, 99);
    if (pick < 40)      r.op = OP_LOAD;
    else if (pick < 72) r.op = OP_STORE;
    else if (pick < 88) r.op = OP_FETCH;
    else                r.op = op_t'($urandom_range(0, 3));
    if ($urandom_range(0, 99) < 85) r.size = 4'(1 << $urandom_range(0, 3));
    else                            r.size = 4'($urandom_range(0, 15));
    r.wdata = {$urandom, $urandom};
    pick = $urandom_range(0, 99);
    off  = '0;
    if (pick < 35) begin
      if (lim != 0) off = 64'($urandom_range(0, win - 1));
      r.addr = cfg_base + off;
    end else if (pick < 55) begin
      if (lim != 0) off = 64'(lim - $urandom_range(1, win));
      r.addr = cfg_base + off;
    end else if (pick < 75) begin
      if (lim != 0) off = 64'($urandom_range(0, lim - 1));
      r.addr = cfg_base + off;
    end else if (pick < 85) begin
      r.addr = cfg_base + 64'(lim) + 64'($urandom_range(0, 8)) - 64'd4;
    end else if (pick < 92) begin
      r.addr = cfg_base - 64'($urandom_range(1, 8));
    end else begin
      r.addr = {$urandom, $urandom};
    end
    // Never read a byte that was not stored yet: turn such a read into a store.
    if (r.op == OP_FETCH || (r.op == OP_LOAD && (r.size == 4'd1 || r.size == 4'd2 ||
                                                 r.size == 4'd4 || r.size == 4'd8))) begin
      nbytes = (r.op == OP_FETCH) ? FETCH_BYTES : r.size;
      offset = r.addr - cfg_base;
      unread = 1'b0;
      if (r.addr >= cfg_base && (({1'b0, offset} + 65'(nbytes)) <= 65'(cur_limit))) begin
        for (int i = 0; i < nbytes; i++) begin
          if (!byte_written[offset[15:0] + 16'(i)]) unread = 1'b1;
        end
      end
      if (unread) begin
        r.op   = OP_STORE;
        r.size = nbytes;
      end
    end
  endtask

  // Idle request bus with random payload.
  task automatic idle_bus();
    req_bus.valid      <= 1'b0;
    req_bus.operation  <= 2'($urandom_range(0, 3));
    req_bus.address    <= {$urandom, $urandom};
    req_bus.size_bytes <= 4'($urandom_range(0, 15));
    req_bus.write_data <= {$urandom, $urandom};
  endtask

  // Offer one request and queue its expected response on acceptance.
  task automatic offer(input mem_req_t r, input bit use_fixed, input mem_rsp_t fixed_rsp);
    mem_rsp_t p;
    req_bus.valid      <= 1'b1;
    req_bus.operation  <= r.op;
    req_bus.address    <= r.addr;
    req_bus.size_bytes <= r.size;
    req_bus.write_data <= r.wdata;
    do @(posedge clk); while (!req_bus.ready);
    compute_memory_response(r, p);
    awaited_rsp.push_back(use_fixed ? fixed_rsp : p);
    case (r.op)
      OP_LOAD:  n_load++;
      OP_STORE: n_store++;
      OP_FETCH: n_fetch++;
      default:  n_noop++;
    endcase
    @(negedge clk);
  endtask

  // Random gap after a burst; zero gaps keep the bus busy.
  task automatic idle_gap(input int cycles);
    for (int g = 0; g < cycles; g++) begin
      idle_bus();
      @(negedge clk);
    end
  endtask

  // Wait until every queued response is back, then let the pipe settle.
  task automatic drain();
    idle_bus();
    do @(negedge clk); while (awaited_rsp.size() != 0);
    repeat (DRAIN_SLACK) @(negedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [DATA_W-1:0] data);
    cfg_bus.valid    <= 1'b1;
    cfg_bus.wr_index <= idx;
    cfg_bus.wr_data  <= data;
    do @(posedge clk); while (!cfg_bus.ready);
    if (idx == CFG_BASE_ADDRESS) cfg_base = data;
    else                         cfg_mem_bytes = data[MEMB_W-1:0];
    cur_limit = (cfg_mem_bytes > MEMB_W'(MEM_DEPTH)) ? MEMB_W'(MEM_DEPTH) : cfg_mem_bytes;
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
    @(negedge clk);
  endtask

  // Random requests in bursts; a long output hold or a drain can be forced halfway.
  task automatic run_random(input int count, input bit hold_mid, input bit drain_mid);
    mem_req_t r;
    int       sent;
    int       burst;
    int       gap;
    sent = 0;
    while (sent < count) begin
      if (sent >= count / 2 && (hold_mid || drain_mid)) begin
        if (hold_mid) begin
          // Keep offering while the receiver holds off, so the input stalls.
          long_hold_req = 1'b1;
          for (int k = 0; k < 40; k++) begin
            make_random_request(r);
            offer(r, 1'b0, '0);
          end
          hold_mid = 1'b0;
        end
        if (drain_mid) begin
          drain();
          drain_mid = 1'b0;
        end
      end
      burst = $urandom_range(1, 24);
      for (int b = 0; b < burst && sent < count; b++) begin
        make_random_request(r);
        offer(r, 1'b0, '0);
        sent++;
      end
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      idle_gap(gap);
    end
  endtask

  // Response receiver with its own stall pattern and an optional long hold.
  initial begin : result_sink
    int mode;
    int left;
    rsp_bus.ready = 1'b0;
    mode = 0;
    left = 0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        rsp_bus.ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        long_hold_req = 1'b0;
        n_holds++;
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 3);
          left = $urandom_range(20, 120);
        end
        left--;
        case (mode)
          0:       rsp_bus.ready <= 1'b1;
          1:       rsp_bus.ready <= ($urandom_range(0, 3) != 0);
          2:       rsp_bus.ready <= ($urandom_range(0, 1) != 0);
          default: rsp_bus.ready <= ((left % 5) < 2);
        endcase
      end
    end
  end

  // Compare each accepted response with the oldest expected one.
  always @(posedge clk) begin : check_results
    mem_rsp_t want;
    if (rst_n && rsp_bus.valid && rsp_bus.ready) begin
      if (awaited_rsp.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Cycle %0d: response with no request pending (data %h status %0d)",
                   cycle_count, rsp_bus.read_data, rsp_bus.status);
      end else begin
        want = awaited_rsp.pop_front();
        case (want.status)
          ST_OK:    n_ok++;
          ST_RANGE: n_range++;
          default:  n_size++;
        endcase
        if (rsp_bus.read_data !== want.rdata || rsp_bus.status !== want.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Cycle %0d: read_data exp %h got %h, status exp %0d got %0d",
                     cycle_count, want.rdata, rsp_bus.read_data, want.status,
                     rsp_bus.status);
        end
      end
    end
  end

  // Main stimulus.
  initial begin : stimulus
    logic [ADDR_W-1:0] ph_base [NUM_PHASES];
    logic [DATA_W-1:0] ph_mem  [NUM_PHASES];
    int                ph_items[NUM_PHASES];
    logic [ADDR_W-1:0] b;

    rst_n            = 1'b0;
    req_bus.valid    = 1'b0;
    req_bus.operation  = OP_LOAD;
    req_bus.address    = '0;
    req_bus.size_bytes = '0;
    req_bus.write_data = '0;
    cfg_bus.valid    = 1'b0;
    cfg_bus.wr_index = CFG_BASE_ADDRESS;
    cfg_bus.wr_data  = '0;
    long_hold_req    = 1'b0;
    mismatches = 0;
    n_load = 0; n_store = 0; n_fetch = 0; n_noop = 0;
    n_ok = 0; n_range = 0; n_size = 0;
    n_holds = 0;
    n_settings = 1;
    for (int i = 0; i < MEM_DEPTH; i++) begin
      mem_image[i]    = 8'h00;
      byte_written[i] = 1'b0;
    end
    cfg_base      = RST_BASE_ADDRESS;
    cfg_mem_bytes = MEMB_W'(RST_MEM_BYTES);
    cur_limit     = (cfg_mem_bytes > MEMB_W'(MEM_DEPTH)) ? MEMB_W'(MEM_DEPTH) : cfg_mem_bytes;

    // Directed requests against the reset settings.
    b = RST_BASE_ADDRESS;
    dir_rows.push_back(make_row(OP_STORE, b,        4'd8, 64'h0123_4567_89AB_CDEF, 1, 0, ST_OK));
    dir_rows.push_back(make_row(OP_LOAD,  b,        4'd8, 64'h0, 0, 0, ST_OK));
    dir_rows.push_back(make_row(OP_LOAD,  b + 3,    4'd1, 64'h0, 0, 0, ST_OK));
    dir_rows.push_back(make_row(OP_LOAD,  b + 1,    4'd2, 64'h0, 0, 0, ST_OK));
    // A fetch ignores the size field.
    dir_rows.push_back(make_row(OP_FETCH, b + 2,    4'd0, 64'h0, 0, 0, ST_OK));
    dir_rows.push_back(make_row(OP_STORE, b + 6,    4'd4, 64'hFFEE_DDCC_BBAA_9988, 1, 0, ST_OK));
    dir_rows.push_back(make_row(OP_STORE, b + 8,    4'd8, 64'hFFFF_FFFF_FFFF_FFFF, 1, 0, ST_OK));
    dir_rows.push_back(make_row(OP_LOAD,  b + 4,    4'd8, 64'h0, 0, 0, ST_OK));
    dir_rows.push_back(make_row(OP_STORE, b + 'hFFF8, 4'd8, 64'h0, 1, 0, ST_OK));
    dir_rows.push_back(make_row(OP_STORE, b + 'hFFFF, 4'd1, 64'hFFFF_FFFF_FFFF_FFA5, 1, 0, ST_OK));
    dir_rows.push_back(make_row(OP_LOAD,  b + 'hFFF8, 4'd8, 64'h0, 0, 0, ST_OK));
    dir_rows.push_back(make_row(OP_FETCH, b + 'hFFFC, 4'd7, 64'h0, 0, 0, ST_OK));
    dir_rows.push_back(make_row(OP_FETCH, b + 'hFFFD, 4'd4, 64'h0, 1, 0, ST_RANGE));
    dir_rows.push_back(make_row(OP_LOAD,  b + 'hFFF9, 4'd8, 64'h0, 1, 0, ST_RANGE));
    dir_rows.push_back(make_row(OP_LOAD,  b - 1,    4'd1, 64'h0, 1, 0, ST_RANGE));
    dir_rows.push_back(make_row(OP_LOAD,  64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 64'h0, 1, 0, ST_RANGE));
    dir_rows.push_back(make_row(OP_STORE, 64'h0,    4'd1, 64'h5A, 1, 0, ST_RANGE));
    dir_rows.push_back(make_row(OP_LOAD,  b,        4'd3, 64'h0, 1, 0, ST_SIZE));
    dir_rows.push_back(make_row(OP_STORE, b,        4'd0, 64'h77, 1, 0, ST_SIZE));
    dir_rows.push_back(make_row(OP_LOAD,  b,        4'd15, 64'h0, 1, 0, ST_SIZE));
    // Range is checked before size, with the size as given.
    dir_rows.push_back(make_row(OP_STORE, b + 'hFFF8, 4'd15, 64'h1234, 1, 0, ST_RANGE));
    // The unused operation touches nothing, in range or not.
    dir_rows.push_back(make_row(OP_NONE,  b,        4'd4, 64'h0, 1, 0, ST_SIZE));
    dir_rows.push_back(make_row(OP_NONE,  64'h0,    4'd8, 64'h0, 1, 0, ST_SIZE));
    dir_rows.push_back(make_row(OP_STORE, b + 'h10000, 4'd2, 64'hBEEF, 1, 0, ST_RANGE));
    // Failed requests must leave the last byte unchanged.
    dir_rows.push_back(make_row(OP_LOAD,  b + 'hFFFF, 4'd1, 64'h0, 0, 0, ST_OK));

    // Register settings per phase; phase zero keeps the reset values.
    ph_base[0] = RST_BASE_ADDRESS;              ph_mem[0] = 64'(RST_MEM_BYTES);
    ph_base[1] = 64'h0;                         ph_mem[1] = 64'(MEM_DEPTH);
    ph_base[2] = 64'hFFFF_FFFF_FFFF_FF80;       ph_mem[2] = 64'd256;
    ph_base[3] = {$urandom, $urandom};
    ph_mem[3]  = {$urandom, 15'($urandom), 17'($urandom_range(8, MEM_DEPTH))};
    ph_base[4] = {$urandom, $urandom};          ph_mem[4] = 64'h1_FFFF;
    ph_base[5] = 64'hFFFF_FFFF_FFFF_FFFF;       ph_mem[5] = 64'h0;
    ph_base[6] = RST_BASE_ADDRESS;              ph_mem[6] = 64'd1;
    ph_base[7] = {$urandom, $urandom};          ph_mem[7] = 64'(MEM_DEPTH);
    ph_items[0] = 140; ph_items[1] = 140; ph_items[2] = 140; ph_items[3] = 140;
    ph_items[4] = 140; ph_items[5] = 60;  ph_items[6] = 100; ph_items[7] = 140;

    // Synchronous reset, released on a falling clock edge.
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      offer(dir_rows[i].req, dir_rows[i].fixed, dir_rows[i].rsp);
      idle_gap($urandom_range(0, 2));
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p > 0) begin
        drain();
        write_register(CFG_BASE_ADDRESS, ph_base[p]);
        write_register(CFG_MEMORY_BYTES, ph_mem[p]);
        n_settings++;
      end
      run_random(ph_items[p], (p == 1 || p == 7), (p == 3));
    end

    drain();
    repeat (16) @(negedge clk);

    $display("Requests: %0d loads, %0d stores, %0d fetches, %0d unused-op, %0d settings",
             n_load, n_store, n_fetch, n_noop, n_settings);
    $display("Responses: %0d ok, %0d out of range, %0d bad size; %0d long holds, %0d errors",
             n_ok, n_range, n_size, n_holds, mismatches);
    if (mismatches == 0 && awaited_rsp.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/sbma_pkg.sv
rtl/sbma_req_if.sv
rtl/sbma_rsp_if.sv
rtl/sbma_cfg_if.sv
rtl/sized_byte_memory_access.sv
sim/sized_byte_memory_access_tb.sv
